[hw/rtl/u8u16_pkg.sv]
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by u8u16_decode, u8u16_unit_queue and the top level.
package u8u16_pkg;

	localparam int MAX_UNITS = 4;

	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [20:0] MAX_CODE = 21'h10FFFF;
	localparam logic [20:0] SURR_LO = 21'h00D800;
	localparam logic [20:0] SURR_HI = 21'h00DFFF;
	localparam logic [20:0] MIN_TWO = 21'h000080;
	localparam logic [20:0] MIN_THREE = 21'h000800;
	localparam logic [20:0] MIN_FOUR = 21'h010000;
	localparam logic [15:0] HIGH_BASE = 16'hD800;
	localparam logic [15:0] LOW_BASE = 16'hDC00;

	typedef logic [15:0] unit_t;

	// Code units caused by one byte, first unit at index 0.
	typedef struct packed {
		logic [2:0] count;
		unit_t [MAX_UNITS-1:0] units;
	} unit_group_t;

	// Pending sequence state.
	typedef struct packed {
		logic [20:0] partial;
		logic [1:0] expected;
		logic [1:0] held;
	} dec_state_t;

	// Append one unit to a group; further units beyond the capacity are dropped.
	function automatic unit_group_t add_unit(input unit_group_t g, input unit_t x);
		unit_group_t r;
		r = g;
		if (g.count < 3'(MAX_UNITS)) begin
			r.units[g.count[1:0]] = x;
			r.count = g.count + 3'd1;
		end
		return r;
	endfunction

endpackage

[hw/rtl/u8u16_decode.sv]
// Combinational decode of one byte against the pending sequence state.
// Depends on u8u16_pkg for the state and unit group types.
module u8u16_decode (
	input  logic [7:0]            in_byte,
	input  logic                  eot,
	input  u8u16_pkg::dec_state_t cur,
	output u8u16_pkg::dec_state_t nxt,
	output u8u16_pkg::unit_group_t group
);
	import u8u16_pkg::*;

	always_comb begin
		dec_state_t st;
		unit_group_t g;
		logic fresh;
		logic [20:0] acc;
		logic [20:0] cp;
		logic [20:0] minimum;
		logic [20:0] off;
		logic bad;

		st = cur;
		g = '0;
		fresh = 1'b0;
		acc = {cur.partial[14:0], in_byte[5:0]};
		cp = acc;
		off = cp - MIN_FOUR;
		minimum = (cur.held == 2'd1) ? MIN_TWO : (cur.held == 2'd2) ? MIN_THREE : MIN_FOUR;
		bad = (cp < minimum) || (cp > MAX_CODE) || (cp >= SURR_LO && cp <= SURR_HI);

		if (cur.expected != 2'd0) begin
			if (in_byte[7:6] == 2'b10) begin
				if (cur.expected == 2'd1) begin
					// Final continuation byte: the sequence is complete.
					if (bad) begin
						g = add_unit(g, REPL_UNIT);
					end else if (cp[20:16] == 5'd0) begin
						g = add_unit(g, cp[15:0]);
					end else begin
						g = add_unit(g, HIGH_BASE + {6'd0, off[19:10]});
						g = add_unit(g, LOW_BASE + {6'd0, off[9:0]});
					end
					st = '0;
				end else begin
					st.partial = acc;
					st.expected = cur.expected - 2'd1;
					st.held = cur.held + 2'd1;
				end
			end else begin
				// Broken sequence: one replacement per held byte, then restart.
				for (int k = 0; k < 3; k++) begin
					if (2'(k) < cur.held) begin
						g = add_unit(g, REPL_UNIT);
					end
				end
				st = '0;
				fresh = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end

		if (fresh) begin
			if (in_byte[7] == 1'b0) begin
				g = add_unit(g, {8'd0, in_byte});
			end else if (in_byte inside {[8'hC2:8'hDF]}) begin
				st.partial = {16'd0, in_byte[4:0]};
				st.expected = 2'd1;
				st.held = 2'd1;
			end else if (in_byte inside {[8'hE0:8'hEF]}) begin
				st.partial = {17'd0, in_byte[3:0]};
				st.expected = 2'd2;
				st.held = 2'd1;
			end else if (in_byte inside {[8'hF0:8'hF4]}) begin
				st.partial = {18'd0, in_byte[2:0]};
				st.expected = 2'd3;
				st.held = 2'd1;
			end else begin
				g = add_unit(g, REPL_UNIT);
			end
		end

		// End of text with a sequence still open flushes the held bytes.
		if (eot && st.expected != 2'd0) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < st.held) begin
					g = add_unit(g, REPL_UNIT);
				end
			end
			st = '0;
		end

		nxt = st;
		group = g;
	end

endmodule

[hw/rtl/u8u16_unit_queue.sv]
// Result register: holds the code units of one byte and hands them out one word a cycle while m_tready is high.
// Depends on u8u16_pkg for the unit group type.
module u8u16_unit_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  u8u16_pkg::unit_group_t group,
	output logic                   free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // code_unit[15:0]
	output logic                   m_tlast    // run_last
);
	import u8u16_pkg::*;

	logic [2:0] rem_s2;
	unit_t [MAX_UNITS-1:0] units_s2;
	logic emit;

	assign m_tvalid = (rem_s2 != 3'd0);
	assign m_tdata = units_s2[0];
	assign m_tlast = (rem_s2 == 3'd1);
	assign emit = m_tvalid && m_tready;
	assign free = (rem_s2 == 3'd0) || (m_tlast && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= 3'd0;
		end else if (load) begin
			rem_s2 <= group.count;
		end else if (emit) begin
			rem_s2 <= rem_s2 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			units_s2 <= group.units;
		end else if (emit) begin
			for (int i = 0; i < MAX_UNITS - 1; i++) begin
				units_s2[i] <= units_s2[i+1];
			end
		end
	end

endmodule

[hw/rtl/utf8_to_utf16_decoder_top.sv]
// Top level of the UTF-8 to UTF-16 transcoder: input register, sequence state, decode, result register.
// Depends on u8u16_pkg, u8u16_decode and u8u16_unit_queue.
//
// The block takes one UTF-8 byte per word on the slave side and sends UTF-16 code units on the
// master side, with tlast set on the last code unit that a byte causes. A byte on the slave side
// enters an input register; once the result register is free, the decode logic combines it with
// the pending sequence state and loads all code units it causes (zero to four) into the result
// register, which hands them out one word per cycle while the master side is ready. A byte that
// yields no or one code unit does not hold up the next, so plain text flows at one byte per clock
// on the same terms. A byte that yields more (a surrogate pair, or replacements from a broken
// sequence) holds the result register until its last unit is taken, and the slave side stalls
// meanwhile. Stalls on the master side back up through the result and input registers without
// loss. Invalid leads, broken or incomplete sequences, overlong forms, surrogates and values
// above 10FFFF become U+FFFD; tlast on the input marks end of text and flushes any open sequence.
module utf8_to_utf16_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // in_byte[7:0]
	input  logic        s_tlast,    // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // code_unit[15:0]
	output logic        m_tlast     // run_last
);
	import u8u16_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// Pending sequence state, updated when the registered byte is decoded.
	dec_state_t state_q;
	dec_state_t state_next;
	unit_group_t group;

	logic free;
	logic advance;

	// The registered byte moves on once the result register can take its units.
	assign advance = valid_s1 && free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eot_s1 <= s_tlast;
		end
	end

	u8u16_decode u_decode (
		.in_byte (byte_s1),
		.eot     (eot_s1),
		.cur     (state_q),
		.nxt     (state_next),
		.group   (group)
	);

	u8u16_unit_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.group    (group),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[hw/rtl/u8u16_checker.sv]
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to the top level.
// Depends on utf8_to_utf16_decoder_top for the bind target.
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);
	logic [1:0] run_cnt_q;
	logic       high_seen_q;
	logic       emit;

	assign emit = m_tvalid && m_tready;

	// Words sent since the last tlast, and whether the last word was a high surrogate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= 2'd0;
			high_seen_q <= 1'b0;
		end else if (emit) begin
			run_cnt_q <= m_tlast ? 2'd0 : run_cnt_q + 2'd1;
			high_seen_q <= (m_tdata[15:10] == 6'b110110);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && run_cnt_q == 2'd3 |-> m_tlast)
		else $error("more than four words for one byte");

	a_high_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:10] == 6'b110110 |-> !m_tlast)
		else $error("high surrogate ends a run");

	a_low_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && high_seen_q |-> m_tdata[15:10] == 6'b110111 && m_tlast)
		else $error("high surrogate not followed by closing low surrogate");

endmodule

bind utf8_to_utf16_decoder_top u8u16_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
